// ===== rtl/assert_macros.svh =====
// assertion macros shared by the backlight fade controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/blc_pkg.sv =====
// types, codes and helper functions of the backlight fade controller
package blc_pkg;

	localparam int LVL_W   = 8;
	localparam int DELAY_W = 16;
	localparam int CMD_W   = 3;
	localparam int IDX_W   = 2;

	localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SLEEP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WAKE     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DIM      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DAY_MODE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LCD_FADE = 3'd5;
	localparam logic [CMD_W-1:0] CMD_KBD_FADE = 3'd6;
	localparam logic [CMD_W-1:0] CMD_REINIT   = 3'd7;

	localparam logic [IDX_W-1:0] REG_LCD_DAY   = 2'd0;
	localparam logic [IDX_W-1:0] REG_LCD_NIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_KBD_DAY   = 2'd2;
	localparam logic [IDX_W-1:0] REG_KBD_NIGHT = 2'd3;

	localparam logic [LVL_W-1:0] DIM_FLOOR = 8'd4;
	localparam logic [LVL_W-1:0] LVL_FULL  = 8'd255;

	// floor(x/10) == (x*205)>>11 for every x below 1029
	localparam logic [17:0] RECIP_10 = 18'd205;
	localparam int          RECIP_SH = 11;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic               is_day;
		logic               instant;
		logic [DELAY_W-1:0] delay_ms;
	} blc_req_t;

	typedef struct packed {
		logic [LVL_W-1:0] lcd_duty;
		logic [LVL_W-1:0] kbd_duty;
		logic             lcd_pwm_held;
		logic             kbd_pwm_held;
		logic             lcd_fading;
		logic             kbd_fading;
		logic             needs_restore;
		logic             sleeping;
	} blc_rsp_t;

	typedef struct packed {
		logic               tick;
		logic               start;
		logic               zero;
		logic               instant;
		logic [DELAY_W-1:0] delay;
		logic [LVL_W-1:0]   target;
	} blc_chan_ctl_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [LVL_W-1:0] level_nx;
		logic             active;
		logic             active_nx;
	} blc_chan_stat_t;

	// max(4, floor(base*3/10))
	function automatic logic [LVL_W-1:0] dim_level(input logic [LVL_W-1:0] base);
		logic [9:0]       tri_x;
		logic [17:0]      prod;
		logic [LVL_W-1:0] t;
		tri_x = {2'b00, base} + {1'b0, base, 1'b0};
		prod  = {8'd0, tri_x} * RECIP_10;
		t     = LVL_W'(prod >> RECIP_SH);
		return (t < DIM_FLOOR) ? DIM_FLOOR : t;
	endfunction

	function automatic logic [LVL_W-1:0] target_of(input logic asleep, input logic dim,
			input logic [LVL_W-1:0] base);
		logic [LVL_W-1:0] t;
		if (asleep) begin
			t = '0;
		end else if (dim) begin
			t = dim_level(base);
		end else begin
			t = base;
		end
		return t;
	endfunction

endpackage

// ===== rtl/blc_channel.sv =====
// one fade engine: level, accumulator, step and tick countdown of a channel
`include "assert_macros.svh"

module blc_channel #(
	parameter int FADE_STEPS = 30,
	parameter int STEP_TICKS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  blc_pkg::blc_chan_ctl_t ctl,
	output blc_pkg::blc_chan_stat_t stat
);

	localparam int LVL_W = blc_pkg::LVL_W;
	localparam int MAG_W = FRAC_BITS + LVL_W;
	localparam int ACC_W = MAG_W + 2;
	localparam int TAB_N = 2 ** LVL_W;

	// step magnitude per level difference, rounded up
	logic [MAG_W-1:0] norm_tab [TAB_N];

	for (genvar g = 0; g < TAB_N; g++) begin : g_tab
		localparam longint unsigned NUM  = (longint'(g) << FRAC_BITS) + FADE_STEPS - 1;
		localparam longint unsigned SVAL = NUM / FADE_STEPS;
		assign norm_tab[g] = MAG_W'(SVAL);
	end

	logic [LVL_W-1:0]                 level_q, level_d;
	logic                             active_q, active_d;
	logic [LVL_W-1:0]                 target_q, target_d;
	logic signed [ACC_W-1:0]          acc_q, acc_d;
	logic signed [ACC_W-1:0]          step_q, step_d;
	logic [blc_pkg::DELAY_W-1:0]      cnt_q, cnt_d;

	logic [LVL_W-1:0]        base;
	logic                    down;
	logic [LVL_W-1:0]        mag;
	logic [MAG_W-1:0]        mag_fx;
	logic signed [ACC_W-1:0] step_mag;
	logic signed [ACC_W-1:0] step_new;
	logic signed [ACC_W-1:0] acc_start;
	logic signed [ACC_W-1:0] acc_sum;
	logic signed [ACC_W-1:0] tgt_fx;
	logic                    over;
	logic [LVL_W-1:0]        step_lvl;
	logic                    counting;
	logic                    stepping;

	// fade start
	assign base      = ctl.zero ? '0 : level_q;
	assign down      = ctl.target < base;
	assign mag       = down ? (base - ctl.target) : (ctl.target - base);
	assign mag_fx    = ctl.instant ? {mag, {FRAC_BITS{1'b0}}} : norm_tab[mag];
	assign step_mag  = $signed({2'b00, mag_fx});
	assign step_new  = down ? -step_mag : step_mag;
	assign acc_start = $signed({2'b00, base, {FRAC_BITS{1'b0}}});

	// fade step
	assign acc_sum  = acc_q + step_q;
	assign tgt_fx   = $signed({2'b00, target_q, {FRAC_BITS{1'b0}}});
	assign over     = step_q[ACC_W-1] ? (acc_sum < tgt_fx) : (acc_sum > tgt_fx);
	assign step_lvl = (over || acc_sum[ACC_W-1]) ? target_q : acc_sum[FRAC_BITS +: LVL_W];
	assign counting = ctl.tick && active_q && (cnt_q != '0);
	assign stepping = ctl.tick && active_q && (cnt_q == '0);

	always_comb begin
		level_d  = base;
		active_d = active_q;
		target_d = target_q;
		acc_d    = acc_q;
		step_d   = step_q;
		cnt_d    = cnt_q;
		if (counting) begin
			cnt_d = cnt_q - 1'b1;
		end else if (stepping) begin
			acc_d   = acc_sum;
			level_d = step_lvl;
			if (step_lvl == target_q) begin
				active_d = 1'b0;
			end else begin
				cnt_d = blc_pkg::DELAY_W'(STEP_TICKS - 1);
			end
		end else if (ctl.start) begin
			active_d = (base != ctl.target);
			target_d = ctl.target;
			acc_d    = acc_start;
			step_d   = step_new;
			cnt_d    = ctl.delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			active_q <= 1'b0;
			target_q <= '0;
			acc_q    <= '0;
			step_q   <= '0;
			cnt_q    <= '0;
		end else begin
			level_q  <= level_d;
			active_q <= active_d;
			target_q <= target_d;
			acc_q    <= acc_d;
			step_q   <= step_d;
			cnt_q    <= cnt_d;
		end
	end

	assign stat.level     = level_q;
	assign stat.level_nx  = level_d;
	assign stat.active    = active_q;
	assign stat.active_nx = active_d;

	`ASSERT_NEXT(a_fade_ends_on_target, clk, arst_n, stepping && !ctl.zero, active_q || (level_q == $past(target_q)), "fade ended away from its target")
	`ASSERT_NEXT(a_start_runs_if_apart, clk, arst_n, ctl.start && !ctl.tick, active_q == ($past(ctl.target) != $past(base)), "fade start state wrong")
	`ASSERT_SAME(a_active_step_nonzero, clk, arst_n, active_q, step_q != '0, "running fade with zero step")

endmodule

// ===== rtl/backlight_fade_controller_top.sv =====
// top level of the two-channel backlight fade controller
//
//  channel  signals                              word
//  -------  -----------------------------------  ------------------------------
//  cfg      cfg_we, cfg_idx, cfg_wdata           one 8-bit level register
//  req      req_valid, req_ready, req_data       command, is_day, instant, delay
//  rsp      rsp_valid, rsp_ready, rsp_data       duties, held, fading, flags
//
// every request word is decoded and applied to both fade engines in the cycle
// it is accepted, and its response word is registered at that same edge, so a
// new word can enter on every clock unless a response word waits on rsp_ready
// req_ready is low only while a response word waits and rsp_ready is low
// reset clears the asleep and dim flags and sets the day flag, clears both
// engines and the response valid; the level registers come out of reset at 255
// one response word per request word, in order

`include "assert_macros.svh"

module backlight_fade_controller_top #(
	parameter int FADE_STEPS = 30,
	parameter int STEP_TICKS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [blc_pkg::IDX_W-1:0]       cfg_idx,
	input  logic [blc_pkg::LVL_W-1:0]       cfg_wdata,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  blc_pkg::blc_req_t               req_data,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output blc_pkg::blc_rsp_t               rsp_data
);

	// level registers
	logic [blc_pkg::LVL_W-1:0] lcd_day_q, lcd_night_q, kbd_day_q, kbd_night_q;

	// mode flags
	logic asleep_q, dim_q, day_q;
	logic asleep_d, dim_d, day_d;

	// decoded actions
	logic                        accept;
	logic                        tick;
	logic                        lcd_start;
	logic                        kbd_req;
	logic                        kbd_force;
	logic                        zero_lvl;
	logic                        fade_instant;
	logic [blc_pkg::DELAY_W-1:0] fade_delay;
	logic [blc_pkg::LVL_W-1:0]   day_sel_lvl;

	blc_pkg::blc_chan_ctl_t  lcd_ctl, kbd_ctl;
	blc_pkg::blc_chan_stat_t lcd_stat, kbd_stat;

	logic [blc_pkg::LVL_W-1:0] lcd_base, kbd_base, lcd_sel_nx;
	blc_pkg::blc_rsp_t         rsp_d, rsp_q;

	// the output register takes a new word when empty or when its word leaves this cycle
	assign req_ready = !rsp_valid || rsp_ready;
	assign accept    = req_valid && req_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcd_day_q   <= blc_pkg::LVL_FULL;
			lcd_night_q <= blc_pkg::LVL_FULL;
			kbd_day_q   <= blc_pkg::LVL_FULL;
			kbd_night_q <= blc_pkg::LVL_FULL;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				blc_pkg::REG_LCD_DAY:   lcd_day_q   <= cfg_wdata;
				blc_pkg::REG_LCD_NIGHT: lcd_night_q <= cfg_wdata;
				blc_pkg::REG_KBD_DAY:   kbd_day_q   <= cfg_wdata;
				blc_pkg::REG_KBD_NIGHT: kbd_night_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// lcd level that the requested day/night mode would select
	assign day_sel_lvl = req_data.is_day ? lcd_day_q : lcd_night_q;

	// command decode: next flags and which engines start
	always_comb begin
		asleep_d     = asleep_q;
		dim_d        = dim_q;
		day_d        = day_q;
		tick         = 1'b0;
		lcd_start    = 1'b0;
		kbd_req      = 1'b0;
		kbd_force    = 1'b0;
		zero_lvl     = 1'b0;
		fade_instant = 1'b0;
		fade_delay   = '0;
		unique case (req_data.cmd)
			blc_pkg::CMD_TICK: begin
				tick = 1'b1;
			end
			blc_pkg::CMD_SLEEP: begin
				dim_d = 1'b0;
				if (!asleep_q) begin
					asleep_d  = 1'b1;
					lcd_start = 1'b1;
					kbd_req   = 1'b1;
				end
			end
			blc_pkg::CMD_WAKE: begin
				dim_d    = 1'b0;
				asleep_d = 1'b0;
				// when wake restarts the fades, it cancels a running keyboard fade and restarts it
				if (asleep_q || dim_q || (lcd_stat.level < blc_pkg::DIM_FLOOR)) begin
					lcd_start    = 1'b1;
					kbd_force    = 1'b1;
					fade_instant = asleep_q;
				end
			end
			blc_pkg::CMD_DIM: begin
				if (!asleep_q && !dim_q) begin
					dim_d     = 1'b1;
					lcd_start = 1'b1;
					kbd_req   = 1'b1;
				end
			end
			blc_pkg::CMD_DAY_MODE: begin
				if (lcd_stat.level != day_sel_lvl) begin
					day_d     = req_data.is_day;
					lcd_start = 1'b1;
					kbd_req   = 1'b1;
				end
			end
			blc_pkg::CMD_LCD_FADE: begin
				lcd_start    = 1'b1;
				fade_instant = req_data.instant;
				fade_delay   = req_data.delay_ms;
			end
			blc_pkg::CMD_KBD_FADE: begin
				kbd_req      = 1'b1;
				fade_instant = req_data.instant;
				fade_delay   = req_data.delay_ms;
			end
			blc_pkg::CMD_REINIT: begin
				asleep_d   = 1'b0;
				zero_lvl   = 1'b1;
				lcd_start  = 1'b1;
				kbd_req    = 1'b1;
				fade_delay = req_data.delay_ms;
			end
			default: ;
		endcase
	end

	// targets follow the flags as they stand after this word
	assign lcd_base = day_d ? lcd_day_q : lcd_night_q;
	assign kbd_base = day_d ? kbd_day_q : kbd_night_q;

	always_comb begin
		lcd_ctl.tick    = accept && tick;
		lcd_ctl.start   = accept && lcd_start;
		lcd_ctl.zero    = accept && zero_lvl;
		lcd_ctl.instant = fade_instant;
		lcd_ctl.delay   = fade_delay;
		lcd_ctl.target  = blc_pkg::target_of(asleep_d, dim_d, lcd_base);

		// a keyboard fade request is dropped while one is running
		kbd_ctl.tick    = accept && tick;
		kbd_ctl.start   = accept && (kbd_force || (kbd_req && !kbd_stat.active));
		kbd_ctl.zero    = accept && zero_lvl;
		kbd_ctl.instant = fade_instant;
		kbd_ctl.delay   = fade_delay;
		kbd_ctl.target  = blc_pkg::target_of(asleep_d, dim_d, kbd_base);
	end

	blc_channel #(
		.FADE_STEPS (FADE_STEPS),
		.STEP_TICKS (STEP_TICKS),
		.FRAC_BITS  (FRAC_BITS)
	) u_lcd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lcd_ctl),
		.stat   (lcd_stat)
	);

	blc_channel #(
		.FADE_STEPS (FADE_STEPS),
		.STEP_TICKS (STEP_TICKS),
		.FRAC_BITS  (FRAC_BITS)
	) u_kbd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (kbd_ctl),
		.stat   (kbd_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asleep_q <= 1'b0;
			dim_q    <= 1'b0;
			day_q    <= 1'b1;
		end else if (accept) begin
			asleep_q <= asleep_d;
			dim_q    <= dim_d;
			day_q    <= day_d;
		end
	end

	// response word from the state as it stands after this word
	assign lcd_sel_nx = day_d ? lcd_day_q : lcd_night_q;

	always_comb begin
		rsp_d.lcd_duty      = lcd_stat.level_nx;
		rsp_d.kbd_duty      = kbd_stat.level_nx;
		rsp_d.lcd_pwm_held  = (lcd_stat.level_nx == blc_pkg::LVL_FULL);
		rsp_d.kbd_pwm_held  = (kbd_stat.level_nx == blc_pkg::LVL_FULL);
		rsp_d.lcd_fading    = lcd_stat.active_nx;
		rsp_d.kbd_fading    = kbd_stat.active_nx;
		rsp_d.needs_restore = !asleep_d && !dim_d && (lcd_sel_nx != '0)
			&& (lcd_stat.level_nx < blc_pkg::DIM_FLOOR);
		rsp_d.sleeping      = asleep_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (accept) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	// response payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_data = rsp_q;

	`ASSERT_NEXT(a_rsp_tracks_state, clk, arst_n, accept, (rsp_q.sleeping == asleep_q) && (rsp_q.lcd_duty == lcd_stat.level), "response word out of step with state")
	`ASSERT_NEXT(a_sleep_reports_asleep, clk, arst_n, accept && (req_data.cmd == blc_pkg::CMD_SLEEP), rsp_valid && rsp_q.sleeping, "sleep word did not report asleep")
	`ASSERT_NEXT(a_rsp_held, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_q), "waiting response word changed")

endmodule
